[hdl/hgps_pkg.sv]
package hgps_pkg;

    // Default structure of the block.
    localparam int NUM_LEGS_DEF   = 6;
    localparam int COUNT_BITS_DEF = 11;

    // Fixed field widths.
    localparam int OUT_LEGS     = 6;
    localparam int FLAG_BITS    = 6;
    localparam int TIME_BITS    = 12;
    localparam int TICK_BITS    = 10;
    localparam int STEPS_BITS   = 8;
    localparam int OFFSET_BITS  = 10;
    localparam int OFFSETS_BITS = 60;
    localparam int START_BITS   = 18;
    localparam int CFG_IDX_BITS = 2;
    localparam int END_BONUS    = 3;

    // Register reset values.
    localparam logic [TICK_BITS-1:0]  PERIOD_RST = 10'd100;
    localparam logic [TICK_BITS-1:0]  STANCE_RST = 10'd50;
    localparam logic [STEPS_BITS-1:0] STEPS_RST  = 8'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PERIOD  = 2'd0,
        CFG_STANCE  = 2'd1,
        CFG_STEPS   = 2'd2,
        CFG_OFFSETS = 2'd3
    } cfg_index_t;

    // Control shared by all leg lanes.
    typedef struct packed {
        logic                 load;
        logic                 advance;
        logic                 startup;
        logic [TICK_BITS-1:0] period;
        logic [TICK_BITS-1:0] stance;
    } lane_ctrl_t;

    // What one lane reports for the current tick.
    typedef struct packed {
        logic signed [TIME_BITS-1:0] time_val;
        logic                        swing;
        logic                        change;
    } lane_result_t;

    // One packed result item.
    typedef struct packed {
        logic [OUT_LEGS-1:0][TIME_BITS-1:0] times;
        logic [FLAG_BITS-1:0]               swing_flags;
        logic [FLAG_BITS-1:0]               change_flags;
    } out_item_t;

endpackage

[hdl/hgps_if.sv]
// Tick channel: one gait tick with the body's stance and end-of-workspace flags.
interface hgps_tick_if;
    logic                            valid;
    logic                            ready;
    logic                            stop;
    logic [hgps_pkg::FLAG_BITS-1:0]  stance_flags;
    logic [hgps_pkg::FLAG_BITS-1:0]  at_end_flags;

    modport source (output valid, stop, stance_flags, at_end_flags, input ready);
    modport sink   (input valid, stop, stance_flags, at_end_flags, output ready);
endinterface

// Phase channel: per-leg phase times and flags.
interface hgps_phase_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [hgps_pkg::TIME_BITS-1:0]  time_leg0;
    logic signed [hgps_pkg::TIME_BITS-1:0]  time_leg1;
    logic signed [hgps_pkg::TIME_BITS-1:0]  time_leg2;
    logic signed [hgps_pkg::TIME_BITS-1:0]  time_leg3;
    logic signed [hgps_pkg::TIME_BITS-1:0]  time_leg4;
    logic signed [hgps_pkg::TIME_BITS-1:0]  time_leg5;
    logic [hgps_pkg::FLAG_BITS-1:0]         swing_flags;
    logic [hgps_pkg::FLAG_BITS-1:0]         change_flags;

    modport source (output valid, time_leg0, time_leg1, time_leg2, time_leg3, time_leg4,
                    time_leg5, swing_flags, change_flags, input ready);
    modport sink   (input valid, time_leg0, time_leg1, time_leg2, time_leg3, time_leg4,
                    time_leg5, swing_flags, change_flags, output ready);
endinterface

// Configuration write channel.
interface hgps_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [hgps_pkg::CFG_IDX_BITS-1:0]   index;
    logic [hgps_pkg::OFFSETS_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/hgps_leg_lane.sv]
module hgps_leg_lane #(
    parameter int COUNT_BITS = hgps_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hgps_pkg::lane_ctrl_t                  ctrl,
    input  logic [hgps_pkg::OFFSET_BITS-1:0]      offset,
    input  logic                                  stance_bit,
    input  logic                                  end_bit,
    output hgps_pkg::lane_result_t                result
);
    import hgps_pkg::*;

    // Working width holds the counter, the period plus one and the counter plus the end bonus.
    localparam int WIDE = ((COUNT_BITS > TICK_BITS) ? COUNT_BITS : TICK_BITS) + 1;
    localparam logic [WIDE-1:0] COUNT_MAX = WIDE'((1 << COUNT_BITS) - 1);
    localparam logic signed [WIDE:0] TIME_HI = (WIDE+1)'((1 << (TIME_BITS - 1)) - 1);
    localparam logic signed [WIDE:0] TIME_LO = -TIME_HI - (WIDE+1)'(1);

    logic [COUNT_BITS-1:0]        counter_reg, counter_next;
    logic signed [TIME_BITS-1:0]  time_reg, time_next;
    logic                         swing_reg, swing_next;
    logic                         stance_armed_reg, stance_armed_next;
    logic                         end_armed_reg, end_armed_next;

    logic [WIDE-1:0]              stance_w, period_w, base_w;
    logic                         fire_stance, fire_end;
    logic [COUNT_BITS-1:0]        cnt_after_stance, cnt_after_end, cnt_up, cnt_base;
    logic                         swing_after_stance, swing_after_end, swing_base;
    logic                         near_period;
    logic signed [WIDE:0]         diff;
    logic signed [TIME_BITS-1:0]  time_base;

    function automatic logic [COUNT_BITS-1:0] sat_count(input logic [WIDE-1:0] v);
        sat_count = (v > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0] : v[COUNT_BITS-1:0];
    endfunction

    // Run mode events: a stance start restarts the counter, an end event jumps into swing.
    always_comb
    begin
        stance_w           = WIDE'(ctrl.stance);
        period_w           = WIDE'(ctrl.period);
        fire_stance        = stance_bit & stance_armed_reg;
        cnt_after_stance   = fire_stance ? '0 : counter_reg;
        swing_after_stance = fire_stance ? 1'b0 : swing_reg;
        fire_end           = end_bit & end_armed_reg;
        cnt_after_end      = fire_end ?
                             sat_count(WIDE'(cnt_after_stance) + WIDE'(END_BONUS)) :
                             cnt_after_stance;
        swing_after_end    = fire_end | swing_after_stance;
        cnt_up             = sat_count(WIDE'(counter_reg) + WIDE'(1));
    end

    // Counter and phase of this tick, then the time within the phase.
    always_comb
    begin
        cnt_base    = ctrl.startup ? cnt_up : cnt_after_end;
        base_w      = WIDE'(cnt_base);
        swing_base  = ctrl.startup ? (base_w >= stance_w) : swing_after_end;
        near_period = (base_w + WIDE'(1) >= period_w) && (base_w <= period_w + WIDE'(1));
        if (swing_base)
        begin
            diff = $signed({1'b0, base_w}) - $signed({1'b0, stance_w});
        end
        else
        begin
            diff = $signed({1'b0, base_w});
        end
        if (diff > TIME_HI)
        begin
            time_base = TIME_HI[TIME_BITS-1:0];
        end
        else if (diff < TIME_LO)
        begin
            time_base = TIME_LO[TIME_BITS-1:0];
        end
        else
        begin
            time_base = diff[TIME_BITS-1:0];
        end
    end

    // Next state of the lane.
    always_comb
    begin
        counter_next      = counter_reg;
        time_next         = time_reg;
        swing_next        = swing_reg;
        stance_armed_next = stance_armed_reg;
        end_armed_next    = end_armed_reg;
        if (ctrl.load)
        begin
            counter_next = sat_count(WIDE'(offset));
            swing_next   = WIDE'(offset) > stance_w;
        end
        else if (ctrl.advance)
        begin
            time_next  = time_base;
            swing_next = swing_base;
            if (ctrl.startup)
            begin
                counter_next = near_period ? '0 : cnt_base;
            end
            else
            begin
                counter_next = (near_period || base_w == stance_w) ?
                               cnt_base : sat_count(base_w + WIDE'(1));
                stance_armed_next = !stance_bit || (stance_armed_reg && !fire_stance);
                end_armed_next    = !stance_bit || (end_armed_reg && !fire_end);
            end
        end
    end

    // Lane state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg      <= '0;
            time_reg         <= '0;
            swing_reg        <= 1'b0;
            stance_armed_reg <= 1'b0;
            end_armed_reg    <= 1'b0;
        end
        else
        begin
            counter_reg      <= counter_next;
            time_reg         <= time_next;
            swing_reg        <= swing_next;
            stance_armed_reg <= stance_armed_next;
            end_armed_reg    <= end_armed_next;
        end
    end

    // Startup reports the stored phase; run mode reports the phase just formed.
    always_comb
    begin
        if (ctrl.startup)
        begin
            result.time_val = time_reg;
            result.swing    = swing_reg;
            result.change   = 1'b0;
        end
        else
        begin
            result.time_val = time_base;
            result.swing    = swing_base;
            result.change   = fire_stance | fire_end;
        end
    end

endmodule

[hdl/hgps_merge.sv]
module hgps_merge #(
    parameter int NUM_LEGS = hgps_pkg::NUM_LEGS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hgps_pkg::lane_result_t  results [NUM_LEGS],
    input  logic                    push,
    output logic                    ready,
    hgps_phase_if.source            phase
);
    import hgps_pkg::*;

    out_item_t  item;
    out_item_t  out_data_reg, out_data_next;
    out_item_t  skid_data_reg, skid_data_next;
    logic       out_valid_reg, out_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    logic       pop;

    // Gather the lane results into one item; legs past the lane count read as zero.
    for (genvar k = 0; k < OUT_LEGS; k++)
    begin : g_pack
        if (k < NUM_LEGS)
        begin : g_used
            assign item.times[k]        = results[k].time_val;
            assign item.swing_flags[k]  = results[k].swing;
            assign item.change_flags[k] = results[k].change;
        end
        else
        begin : g_unused
            assign item.times[k]        = '0;
            assign item.swing_flags[k]  = 1'b0;
            assign item.change_flags[k] = 1'b0;
        end
    end

    assign pop   = out_valid_reg && phase.ready;
    assign ready = !skid_valid_reg;

    // Output register with a skid stage behind it.
    always_comb
    begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = item;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = item;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign phase.valid        = out_valid_reg;
    assign phase.time_leg0    = out_data_reg.times[0];
    assign phase.time_leg1    = out_data_reg.times[1];
    assign phase.time_leg2    = out_data_reg.times[2];
    assign phase.time_leg3    = out_data_reg.times[3];
    assign phase.time_leg4    = out_data_reg.times[4];
    assign phase.time_leg5    = out_data_reg.times[5];
    assign phase.swing_flags  = out_data_reg.swing_flags;
    assign phase.change_flags = out_data_reg.change_flags;

endmodule

[hdl/hexapod_gait_phase_sequencer.sv]
// Channel  Role  Fields                                               Transfer
// tick     in    stop, stance_flags, at_end_flags                     valid && ready
// phase    out   time_leg0..time_leg5, swing_flags, change_flags      valid && ready
// cfg      in    index (0 period, 1 stance, 2 steps, 3 offsets), data valid && ready
//
// A tick is taken while tick ready is high; its result is registered in the output stage.
// All leg lanes update in parallel: one tick per cycle while tick ready is high.
// A stop tick and the tick that ends startup give no result.
// Reset loads all counters, times and swing flags with zero and enters startup mode.
// A stalled phase channel fills the output register and then a skid stage; tick ready
// drops only when both are full. The cfg channel is always ready.
module hexapod_gait_phase_sequencer #(
    parameter int NUM_LEGS   = hgps_pkg::NUM_LEGS_DEF,
    parameter int COUNT_BITS = hgps_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    hgps_tick_if.sink     tick,
    hgps_phase_if.source  phase,
    hgps_cfg_if.sink      cfg
);
    import hgps_pkg::*;

    logic [TICK_BITS-1:0]     period_reg, period_next;
    logic [TICK_BITS-1:0]     stance_reg, stance_next;
    logic [STEPS_BITS-1:0]    steps_reg, steps_next;
    logic [OFFSETS_BITS-1:0]  offsets_reg, offsets_next;
    logic [START_BITS-1:0]    startup_count_reg, startup_count_next;
    logic                     in_startup_reg, in_startup_next;

    logic                     cfg_write, load;
    logic                     tick_accept, tick_live, startup_end, emit;
    logic [START_BITS-1:0]    startup_target, count_inc;
    lane_ctrl_t               ctrl;
    lane_result_t             results [NUM_LEGS];
    logic [NUM_LEGS-1:0]      lane_change;
    logic                     merge_ready;

    assign cfg.ready   = 1'b1;
    assign cfg_write   = cfg.valid && cfg.ready;
    assign tick.ready  = merge_ready;
    assign tick_accept = tick.valid && tick.ready;
    assign tick_live   = tick_accept && !tick.stop;

    // Startup ends after startup_steps full periods.
    assign startup_target = START_BITS'(steps_reg) * START_BITS'(period_reg);
    assign count_inc      = startup_count_reg + START_BITS'(1);
    assign startup_end    = in_startup_reg && (count_inc == startup_target);
    assign emit           = tick_live && !startup_end;

    // Register writes; stance or offset writes before the first tick reload the legs.
    always_comb
    begin
        period_next  = period_reg;
        stance_next  = stance_reg;
        steps_next   = steps_reg;
        offsets_next = offsets_reg;
        load         = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_PERIOD:  period_next  = cfg.data[TICK_BITS-1:0];
                CFG_STANCE:  stance_next  = cfg.data[TICK_BITS-1:0];
                CFG_STEPS:   steps_next   = cfg.data[STEPS_BITS-1:0];
                CFG_OFFSETS: offsets_next = cfg.data;
                default:     period_next  = period_reg;
            endcase
            load = ((cfg_index_t'(cfg.index) == CFG_STANCE) ||
                    (cfg_index_t'(cfg.index) == CFG_OFFSETS)) &&
                   in_startup_reg && (startup_count_reg == '0);
        end
    end

    // Mode control.
    always_comb
    begin
        startup_count_next = startup_count_reg;
        in_startup_next    = in_startup_reg;
        if (tick_live && in_startup_reg)
        begin
            startup_count_next = count_inc;
            if (startup_end)
            begin
                in_startup_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg        <= PERIOD_RST;
            stance_reg        <= STANCE_RST;
            steps_reg         <= STEPS_RST;
            offsets_reg       <= '0;
            startup_count_reg <= '0;
            in_startup_reg    <= 1'b1;
        end
        else
        begin
            period_reg        <= period_next;
            stance_reg        <= stance_next;
            steps_reg         <= steps_next;
            offsets_reg       <= offsets_next;
            startup_count_reg <= startup_count_next;
            in_startup_reg    <= in_startup_next;
        end
    end

    // Lane control; a reload sees the values being written.
    always_comb
    begin
        ctrl.load    = load;
        ctrl.advance = emit;
        ctrl.startup = in_startup_reg;
        ctrl.period  = period_reg;
        ctrl.stance  = stance_next;
    end

    // One lane per leg.
    for (genvar k = 0; k < NUM_LEGS; k++)
    begin : g_lane
        logic [OFFSET_BITS-1:0] lane_offset;
        logic                   lane_stance, lane_end;

        if (k < OUT_LEGS)
        begin : g_flagged
            assign lane_offset = offsets_next[k*OFFSET_BITS +: OFFSET_BITS];
            assign lane_stance = tick.stance_flags[k];
            assign lane_end    = tick.at_end_flags[k];
        end
        else
        begin : g_spare
            assign lane_offset = '0;
            assign lane_stance = 1'b0;
            assign lane_end    = 1'b0;
        end

        hgps_leg_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .offset     (lane_offset),
            .stance_bit (lane_stance),
            .end_bit    (lane_end),
            .result     (results[k])
        );

        assign lane_change[k] = results[k].change;
    end

    // Merge the lanes and buffer the result.
    hgps_merge #(
        .NUM_LEGS (NUM_LEGS)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .results (results),
        .push    (emit),
        .ready   (merge_ready),
        .phase   (phase)
    );

`ifndef NO_ASSERTIONS
    // A stop tick leaves the startup count alone.
    a_stop_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept && tick.stop |=> $stable(startup_count_reg))
        else $error("stop tick changed the startup count");

    // Run mode is left only by reset.
    a_run_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !in_startup_reg |=> !in_startup_reg)
        else $error("block went back to startup mode");

    // Startup ticks never report a phase change.
    a_startup_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        in_startup_reg |-> lane_change == '0)
        else $error("phase change reported during startup");

    // Counters reload only before the first tick of startup.
    a_load_window: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> in_startup_reg && startup_count_reg == '0)
        else $error("leg reload outside its window");
`endif

endmodule

[tb/hexapod_gait_phase_sequencer_checker.sv]
module hexapod_gait_phase_sequencer_checker #(
    parameter int COUNT_BITS = hgps_pkg::COUNT_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    hgps_tick_if  tick,
    hgps_phase_if phase,
    hgps_cfg_if   cfg,
    output int    fail_count,
    output int    pending,
    output int    results_checked,
    output int    phase_changes
);
    timeunit 1ns;
    timeprecision 1ps;

    import hgps_pkg::*;

    localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
    localparam int TIME_MAX  = (1 << (TIME_BITS - 1)) - 1;
    localparam int TIME_MIN  = -(1 << (TIME_BITS - 1));

    // Shadow copy of the registers.
    logic [TICK_BITS-1:0]    period_reg;
    logic [TICK_BITS-1:0]    stance_reg;
    logic [STEPS_BITS-1:0]   steps_reg;
    logic [OFFSETS_BITS-1:0] offsets_reg;

    // Shadow copy of the per-leg state and the startup bookkeeping.
    logic [COUNT_BITS-1:0]       leg_count [OUT_LEGS];
    logic signed [TIME_BITS-1:0] leg_phase_time [OUT_LEGS];
    logic [FLAG_BITS-1:0]        swing_q;
    logic [FLAG_BITS-1:0]        stance_armed_q;
    logic [FLAG_BITS-1:0]        end_armed_q;
    logic [START_BITS-1:0]       startup_ticks;
    logic                        in_startup;

    // Phase reports predicted but not yet seen on the output channel.
    out_item_t phase_reports_due [$];

    function automatic int sat_count(input int c);
        return (c > COUNT_MAX) ? COUNT_MAX : c;
    endfunction

    function automatic logic near_period(input int c);
        return (c + 1 >= int'(period_reg)) && (c <= int'(period_reg) + 1);
    endfunction

    // Time within the phase: swing time is measured from the end of stance.
    function automatic logic signed [TIME_BITS-1:0] phase_time(input int c, input logic swing);
        int t;
        t = swing ? c - int'(stance_reg) : c;
        if (t > TIME_MAX) t = TIME_MAX;
        if (t < TIME_MIN) t = TIME_MIN;
        return TIME_BITS'(t);
    endfunction

    function automatic void reload_offsets();
        int off;
        for (int k = 0; k < OUT_LEGS; k++) begin
            off = int'(offsets_reg[k*OFFSET_BITS +: OFFSET_BITS]);
            leg_count[k] = COUNT_BITS'(sat_count(off));
            swing_q[k]   = off > int'(stance_reg);
        end
    endfunction

    function automatic out_item_t leg_report(input logic [FLAG_BITS-1:0] changed);
        out_item_t item;
        for (int k = 0; k < OUT_LEGS; k++) item.times[k] = leg_phase_time[k];
        item.swing_flags  = swing_q;
        item.change_flags = changed;
        return item;
    endfunction

    function automatic void reset_gait();
        period_reg     = PERIOD_RST;
        stance_reg     = STANCE_RST;
        steps_reg      = STEPS_RST;
        offsets_reg    = '0;
        swing_q        = '0;
        stance_armed_q = '0;
        end_armed_q    = '0;
        startup_ticks  = '0;
        in_startup     = 1'b1;
        for (int k = 0; k < OUT_LEGS; k++) leg_phase_time[k] = '0;
        reload_offsets();
        phase_reports_due.delete();
    endfunction

    // One accepted tick: advances every leg and queues the report it causes.
    function automatic void advance_gait(input logic [FLAG_BITS-1:0] stance_f,
                                         input logic [FLAG_BITS-1:0] end_f);
        logic [START_BITS-1:0] startup_end;
        logic [FLAG_BITS-1:0]  changed;
        out_item_t             item;
        int                    c;
        changed = '0;
        if (in_startup) begin
            startup_ticks = startup_ticks + 1'b1;
            startup_end   = START_BITS'(32'(steps_reg) * 32'(period_reg));
            if (startup_ticks == startup_end) begin
                in_startup = 1'b0;
                return;
            end
            // Free-running legs report the stored values, then move on.
            item = leg_report('0);
            for (int k = 0; k < OUT_LEGS; k++) begin
                c = sat_count(int'(leg_count[k]) + 1);
                swing_q[k] = c >= int'(stance_reg);
                leg_phase_time[k] = phase_time(c, swing_q[k]);
                if (near_period(c)) c = 0;
                leg_count[k] = COUNT_BITS'(c);
            end
            phase_reports_due = {phase_reports_due, item};
            return;
        end
        // Run mode: body events restart or push each leg's counter.
        for (int k = 0; k < OUT_LEGS; k++) begin
            c = int'(leg_count[k]);
            if (stance_f[k] && stance_armed_q[k]) begin
                stance_armed_q[k] = 1'b0;
                c = 0;
                swing_q[k] = 1'b0;
                changed[k] = 1'b1;
            end
            if (!stance_f[k]) stance_armed_q[k] = 1'b1;
            if (end_f[k] && end_armed_q[k]) begin
                end_armed_q[k] = 1'b0;
                c = sat_count(c + END_BONUS);
                swing_q[k] = 1'b1;
                changed[k] = 1'b1;
            end
            if (!stance_f[k]) end_armed_q[k] = 1'b1;
            leg_phase_time[k] = phase_time(c, swing_q[k]);
            if (!near_period(c) && c != int'(stance_reg)) c = sat_count(c + 1);
            leg_count[k] = COUNT_BITS'(c);
        end
        item = leg_report(changed);
        phase_reports_due = {phase_reports_due, item};
    endfunction

    function automatic void write_register(input cfg_index_t idx,
                                           input logic [OFFSETS_BITS-1:0] value);
        case (idx)
            CFG_PERIOD:  period_reg  = value[TICK_BITS-1:0];
            CFG_STANCE:  stance_reg  = value[TICK_BITS-1:0];
            CFG_STEPS:   steps_reg   = value[STEPS_BITS-1:0];
            CFG_OFFSETS: offsets_reg = value;
            default: ;
        endcase
        // Counters follow the offsets only before the first tick after reset.
        if ((idx == CFG_STANCE || idx == CFG_OFFSETS) && in_startup && startup_ticks == '0)
            reload_offsets();
    endfunction

    function automatic void compare_report(input out_item_t want, input out_item_t got);
        for (int k = 0; k < OUT_LEGS; k++) begin
            if (got.times[k] !== want.times[k]) begin
                fail_count++;
                $display("%0t: time_leg%0d expected %0d, got %0d", $time, k,
                         $signed(want.times[k]), $signed(got.times[k]));
            end
        end
        if (got.swing_flags !== want.swing_flags) begin
            fail_count++;
            $display("%0t: swing_flags expected %b, got %b", $time,
                     want.swing_flags, got.swing_flags);
        end
        if (got.change_flags !== want.change_flags) begin
            fail_count++;
            $display("%0t: change_flags expected %b, got %b", $time,
                     want.change_flags, got.change_flags);
        end
    endfunction

    // Sample all three channels at the rising edge.
    always @(posedge clk or negedge rst_n) begin
        out_item_t got;
        out_item_t want;
        if (!rst_n) begin
            reset_gait();
        end
        else begin
            // A result never leaves in the cycle its tick is taken, so check first.
            if (phase.valid && phase.ready) begin
                got.times[0]     = phase.time_leg0;
                got.times[1]     = phase.time_leg1;
                got.times[2]     = phase.time_leg2;
                got.times[3]     = phase.time_leg3;
                got.times[4]     = phase.time_leg4;
                got.times[5]     = phase.time_leg5;
                got.swing_flags  = phase.swing_flags;
                got.change_flags = phase.change_flags;
                if (phase_reports_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: phase transfer expected none, got times %0d %0d %0d %0d %0d %0d",
                             $time, phase.time_leg0, phase.time_leg1, phase.time_leg2,
                             phase.time_leg3, phase.time_leg4, phase.time_leg5);
                    $display("%0t: that transfer carried swing %b change %b",
                             $time, phase.swing_flags, phase.change_flags);
                end
                else begin
                    want = phase_reports_due.pop_front();
                    compare_report(want, got);
                    results_checked++;
                    if (want.change_flags != '0) phase_changes++;
                end
            end
            if (tick.valid && tick.ready && !tick.stop)
                advance_gait(tick.stance_flags, tick.at_end_flags);
            if (cfg.valid && cfg.ready)
                write_register(cfg_index_t'(cfg.index), cfg.data);
        end
        pending = phase_reports_due.size();
    end

endmodule

[tb/hexapod_gait_phase_sequencer_tb.sv]
module hexapod_gait_phase_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hgps_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int STARTUP_PERIOD = 8;
    localparam int STARTUP_STANCE = 3;
    localparam int STARTUP_STEPS  = 130;
    localparam int STARTUP_TICKS  = STARTUP_PERIOD * STARTUP_STEPS;
    localparam int RUN_PHASES     = 6;
    localparam int RUN_ITEMS      = 150;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    int fail_count;
    int pending;
    int results_checked;
    int phase_changes;
    int cycles;
    int ticks_sent;
    int cfg_writes;
    int sender_idle_pct;
    int stall_pct;

    // Stance pattern that the random walk holds between ticks.
    logic [FLAG_BITS-1:0] walk_stance;

    hgps_tick_if  tick_ch ();
    hgps_phase_if phase_ch ();
    hgps_cfg_if   cfg_ch ();

    hexapod_gait_phase_sequencer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick_ch),
        .phase (phase_ch),
        .cfg   (cfg_ch)
    );

    hexapod_gait_phase_sequencer_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick            (tick_ch),
        .phase           (phase_ch),
        .cfg             (cfg_ch),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .phase_changes   (phase_changes)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("hexapod_gait_phase_sequencer verification failed");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        phase_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 85; stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 85; end
            default:       begin sender_idle_pct = 24; stall_pct = 24; end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_tick(input logic stop, input logic [FLAG_BITS-1:0] stance_f,
                             input logic [FLAG_BITS-1:0] end_f);
        while ($urandom_range(99) < sender_idle_pct) begin
            tick_ch.valid = 1'b0;
            @(negedge clk);
        end
        tick_ch.valid        = 1'b1;
        tick_ch.stop         = stop;
        tick_ch.stance_flags = stance_f;
        tick_ch.at_end_flags = end_f;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        @(negedge clk);
        if (!stop) ticks_sent++;
    endtask

    // Mostly a plausible walk: stance bits held in runs, sparse end flags.
    // The rest is raw noise and stop ticks.
    task automatic send_walk_tick(input int toggle_pct, input int end_pct);
        logic [FLAG_BITS-1:0] end_f;
        int                   pick;
        pick = $urandom_range(99);
        if (pick < 3) begin
            send_tick(1'b1, FLAG_BITS'($urandom), FLAG_BITS'($urandom));
        end
        else if (pick < 15) begin
            send_tick(1'b0, FLAG_BITS'($urandom), FLAG_BITS'($urandom));
        end
        else begin
            for (int k = 0; k < FLAG_BITS; k++) begin
                if ($urandom_range(99) < toggle_pct) walk_stance[k] = ~walk_stance[k];
                end_f[k] = ($urandom_range(99) < end_pct);
            end
            send_tick(1'b0, walk_stance, end_f);
        end
    endtask

    // Unused data bits above the register field carry random junk.
    task automatic write_reg(input cfg_index_t idx, input logic [OFFSETS_BITS-1:0] value);
        logic [OFFSETS_BITS-1:0] junk;
        junk = OFFSETS_BITS'({$urandom, $urandom});
        case (idx)
            CFG_PERIOD, CFG_STANCE: cfg_ch.data = {junk[OFFSETS_BITS-1:TICK_BITS],
                                                   value[TICK_BITS-1:0]};
            CFG_STEPS:              cfg_ch.data = {junk[OFFSETS_BITS-1:STEPS_BITS],
                                                   value[STEPS_BITS-1:0]};
            default:                cfg_ch.data = value;
        endcase
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        cfg_writes++;
    endtask

    // Hold the sender until every expected report is back, then let the block settle.
    task automatic drain();
        tick_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int period_v;
        int stance_v;
        int toggle_v;
        int end_v;
        int phase_start;
        logic paused;

        rst_n                = 1'b0;
        tick_ch.valid        = 1'b0;
        tick_ch.stop         = 1'b0;
        tick_ch.stance_flags = '0;
        tick_ch.at_end_flags = '0;
        phase_ch.ready       = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_PERIOD;
        cfg_ch.data          = '0;
        walk_stance          = '0;
        set_idling(IDLE_NONE);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Startup setup: short period so counters wrap often. Offsets cover zero,
        // the 10-bit maximum (climbs to saturation), stance, stance + 1,
        // period - 1 and period + 1.
        write_reg(CFG_PERIOD, STARTUP_PERIOD);
        write_reg(CFG_STANCE, STARTUP_STANCE);
        write_reg(CFG_STEPS, STARTUP_STEPS);
        write_reg(CFG_OFFSETS, {10'(STARTUP_PERIOD + 1), 10'(STARTUP_PERIOD - 1),
                                10'(STARTUP_STANCE + 1), 10'(STARTUP_STANCE),
                                10'd1023, 10'd0});

        // Startup: flags are ignored, stop ticks must not count.
        send_tick(1'b1, '1, '1);
        send_tick(1'b0, '0, '0);
        send_tick(1'b0, '1, '1);
        send_tick(1'b1, '0, '0);
        for (int seg = 0; seg < 4; seg++) begin
            set_idling(idle_mode_t'(seg));
            while (ticks_sent < (seg + 1) * (STARTUP_TICKS / 4)) send_walk_tick(8, 10);
        end

        // First run-mode ticks: arming, stance start, swing start in the same tick,
        // an unarmed end flag, a re-armed end flag, alternating legs, a stop.
        set_idling(IDLE_NONE);
        send_tick(1'b0, 6'h00, 6'h00);
        send_tick(1'b0, 6'h3F, 6'h00);
        send_tick(1'b0, 6'h3F, 6'h3F);
        send_tick(1'b0, 6'h00, 6'h3F);
        send_tick(1'b0, 6'h00, 6'h3F);
        send_tick(1'b0, 6'h2A, 6'h15);
        send_tick(1'b0, 6'h15, 6'h2A);
        send_tick(1'b1, 6'h3F, 6'h3F);
        send_tick(1'b0, 6'h3F, 6'h00);
        send_tick(1'b0, 6'h00, 6'h00);
        drain();

        // Run phases, each under its own register setting and idling pattern.
        for (int p = 0; p < RUN_PHASES; p++) begin
            toggle_v = $urandom_range(2, 12);
            end_v    = $urandom_range(2, 12);
            case (p)
                0: begin
                    period_v = 1023;
                    stance_v = 1022;
                    toggle_v = 1;
                    write_reg(CFG_STEPS, 255);
                end
                1: begin
                    period_v = 2;
                    stance_v = 1;
                    write_reg(CFG_STEPS, 1);
                end
                2: begin
                    period_v = 10;
                    stance_v = 500;
                end
                3: begin
                    period_v = 30;
                    stance_v = 12;
                    write_reg(CFG_OFFSETS, '1);
                end
                default: begin
                    period_v = $urandom_range(2, 100);
                    stance_v = $urandom_range(1) ? $urandom_range(1, 1022)
                                                 : $urandom_range(1, period_v - 1);
                    write_reg(CFG_STEPS, $urandom_range(1, 255));
                    write_reg(CFG_OFFSETS, OFFSETS_BITS'({$urandom, $urandom}));
                end
            endcase
            write_reg(CFG_PERIOD, period_v);
            write_reg(CFG_STANCE, stance_v);
            set_idling(idle_mode_t'(p % 4));

            phase_start = ticks_sent;
            paused      = 1'b0;
            while (ticks_sent - phase_start < RUN_ITEMS) begin
                // Once, stop feeding halfway until the output side has caught up.
                if (p == 4 && !paused && ticks_sent - phase_start >= RUN_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                send_walk_tick(toggle_v, end_v);
            end
            drain();
        end

        $display("Run covered %0d ticks (%0d in startup) and %0d register writes;",
                 ticks_sent, STARTUP_TICKS, cfg_writes);
        $display("%0d phase reports checked, %0d of them with a phase change, in %0d cycles.",
                 results_checked, phase_changes, cycles);
        if (fail_count == 0) begin
            $display("hexapod_gait_phase_sequencer verification clean");
        end
        else begin
            $display("%0d mismatches", fail_count);
            $display("hexapod_gait_phase_sequencer verification failed");
        end
        $finish;
    end

endmodule

[files.f]
hdl/hgps_pkg.sv
hdl/hgps_if.sv
hdl/hgps_leg_lane.sv
hdl/hgps_merge.sv
hdl/hexapod_gait_phase_sequencer.sv
tb/hexapod_gait_phase_sequencer_checker.sv
tb/hexapod_gait_phase_sequencer_tb.sv
